### sv/bdqd_pkg.sv
// Package for the button debounce and quadrature decode block.
// Holds the transaction payload structs and the encoder codes; no dependencies.
`timescale 1ns / 1ps

package bdqd_pkg;

  localparam int unsigned ButtonW = 8;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned PosW    = 32;
  localparam int unsigned ErrW    = 16;

  localparam logic [ButtonW-1:0] DebounceTicksReset = 8'd10;
  localparam logic [ButtonW-1:0] CounterMax         = 8'hFF;
  localparam logic [ErrW-1:0]    ErrorMax           = 16'hFFFF;

  // Phase change patterns of interest.
  localparam logic [PhaseW-1:0] EncLowBit = 2'b01;
  localparam logic [PhaseW-1:0] EncBoth   = 2'b11;

  typedef struct packed {
    logic [ButtonW-1:0] raw_buttons;
    logic [PhaseW-1:0]  enc_phases;
    logic               ack_changes;
  } bdqd_in_t;

  typedef struct packed {
    logic [ButtonW-1:0]     stable_buttons;
    logic [ButtonW-1:0]     stable_before;
    logic [ButtonW-1:0]     changed_map;
    logic signed [PosW-1:0] position;
    logic [ErrW-1:0]        error_count;
  } bdqd_out_t;

endpackage

### sv/button_debounce_and_quadrature_decode_top.sv
// Top level of the button debounce and quadrature decode block.
// Depends on bdqd_pkg for the payload structs and encoder codes.
`timescale 1ns / 1ps

// Each input transaction is one sampling tick and yields exactly one result
// transaction, which appears in the output register in the cycle after the tick
// is accepted. The block takes a tick in every cycle unless the output stalls:
// all per-pin settle counters, the change map and the encoder state are updated
// by one short combinational pass at the accepting edge, so throughput is one
// tick per cycle. The output register holds a result while the consumer stalls,
// and a new tick is accepted whenever that register is empty or is being
// emptied in the same cycle. The debounce period is written
// through cfg_we_i/cfg_data_i and should only be changed while the block is idle.
module button_debounce_and_quadrature_decode_top #(
  parameter int unsigned PINS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bdqd_pkg::bdqd_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bdqd_pkg::bdqd_out_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic [bdqd_pkg::ButtonW-1:0] cfg_data_i
);
  import bdqd_pkg::*;

  // Pin vectors are at least as wide as the button field so that the result
  // can always be taken from the low bits.
  localparam int unsigned PinW = (PINS > ButtonW) ? PINS : ButtonW;

  logic               accept;
  logic [ButtonW-1:0] debounce_q;
  logic [ButtonW-1:0] reload;
  logic [PinW-1:0]    pin_mask;
  logic [PinW-1:0]    raw;
  logic [PinW-1:0]    toggled;
  logic [PinW-1:0]    settled;
  logic [PinW-1:0]    last_raw_q;
  logic [PinW-1:0]    stable_q, stable_d;
  logic [PinW-1:0]    accum_q, accum_d, accum_rep;
  logic [PhaseW-1:0]  phases_q;
  logic [PhaseW-1:0]  phase_diff;
  logic               dir;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [ErrW-1:0]    err_q, err_d;
  logic               out_valid_q;
  bdqd_out_t          out_q, out_d;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;

  // The reload value saturates when the period is at its maximum.
  assign reload = (debounce_q == CounterMax) ? CounterMax : debounce_q + 8'd1;

  always_comb begin
    for (int i = 0; i < PinW; i++) begin
      pin_mask[i] = (i < PINS);
    end
  end

  assign raw     = PinW'(in_data_i.raw_buttons) & pin_mask;
  assign toggled = raw ^ last_raw_q;

  // One settle counter per pin; settled marks used pins that did not toggle and whose counter is already zero.
  for (genvar g = 0; g < PinW; g++) begin : g_pin
    if (g < PINS) begin : g_used
      logic [ButtonW-1:0] cnt_q, cnt_d;

      always_comb begin
        cnt_d = cnt_q;
        if (toggled[g]) begin
          cnt_d = reload;
        end else if (cnt_q != '0) begin
          cnt_d = cnt_q - 8'd1;
        end
      end

      assign settled[g] = !toggled[g] && (cnt_q == '0);

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          cnt_q <= '0;
        end else if (accept) begin
          cnt_q <= cnt_d;
        end
      end
    end else begin : g_unused
      assign settled[g] = 1'b0;
    end
  end

  assign stable_d  = (stable_q & ~settled) | (raw & settled);
  assign accum_rep = accum_q | (stable_d ^ stable_q);
  assign accum_d   = in_data_i.ack_changes ? '0 : accum_rep;

  assign phase_diff = in_data_i.enc_phases ^ phases_q;
  assign dir        = in_data_i.enc_phases[1] ^ phases_q[0];

  always_comb begin
    pos_d = pos_q;
    err_d = err_q;
    case (phase_diff)
      EncBoth: begin
        if (err_q != ErrorMax) begin
          err_d = err_q + 16'd1;
        end
      end
      EncLowBit: begin
        pos_d = dir ? pos_q + 32'd1 : pos_q - 32'd1;
      end
      default: begin
        pos_d = pos_q;
      end
    endcase
  end

  always_comb begin
    out_d.stable_buttons = stable_d[ButtonW-1:0];
    out_d.stable_before  = stable_q[ButtonW-1:0];
    out_d.changed_map    = accum_rep[ButtonW-1:0];
    out_d.position       = pos_d;
    out_d.error_count    = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceTicksReset;
      last_raw_q  <= '0;
      stable_q    <= '0;
      accum_q     <= '0;
      phases_q    <= '0;
      pos_q       <= '0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        debounce_q <= cfg_data_i;
      end
      if (accept) begin
        last_raw_q  <= raw;
        stable_q    <= stable_d;
        accum_q     <= accum_d;
        phases_q    <= in_data_i.enc_phases;
        pos_q       <= pos_d;
        err_q       <= err_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Every accepted tick leaves a result waiting in the output register.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted tick produced no result");

  // The reported previous state is the stable state held before the tick.
  a_before_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_data_o.stable_before == $past(stable_q[ButtonW-1:0])))
    else $error("stable_before does not match the held stable state");

  // The error tally only ever grows.
  a_err_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q >= $past(err_q))
    else $error("error tally decreased");

  // Pins beyond the configured count never become stable or flagged.
  a_unused_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((stable_q & ~pin_mask) == '0) && ((accum_q & ~pin_mask) == '0))
    else $error("unused pin bit set");

endmodule
